// File: hw/rtl/msta_pkg.sv
// Shared types and constants for the multi-sensor threshold alarm.
// No dependencies; imported by every module of the block.
package msta_pkg;

	localparam int CHANNELS   = 4;
	localparam int TIME_WIDTH = 32;

	localparam int READ_W   = 16;
	localparam int LIMIT_W  = 16;
	localparam int DELAY_W  = 32;
	localparam int TICK_W   = 16;
	localparam int FLAG_W   = 4;
	localparam int CMP_W    = (TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_TDATA_W  = 4 * READ_W;
	localparam int OUT_BITS    = 1 + 3 * FLAG_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUMID_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUST_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALERT_DLY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REBUZZ_INT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PER   = 3'd7;

	typedef struct packed {
		logic [LIMIT_W-1:0] temp_high_limit;
		logic [LIMIT_W-1:0] temp_low_limit;
		logic [LIMIT_W-1:0] humidity_high_limit;
		logic [LIMIT_W-1:0] dust_high_limit;
		logic [LIMIT_W-1:0] light_low_limit;
		logic [DELAY_W-1:0] alert_delay_ms;
		logic [DELAY_W-1:0] rebuzz_interval_ms;
		logic [TICK_W-1:0]  tick_period_ms;
	} cfg_t;

	// temp in the lowest bits, matching the input word layout
	typedef struct packed {
		logic [READ_W-1:0] light_reading;
		logic [READ_W-1:0] dust_reading;
		logic [READ_W-1:0] humidity_reading;
		logic [READ_W-1:0] temp_reading;
	} rd_t;

	typedef struct packed {
		logic buzz;
		logic bad;
		logic alert;
		logic recov;
	} chan_evt_t;

endpackage

// File: hw/rtl/msta_cfg_regs.sv
// Configuration register file: limits, delays and tick period.
// Depends on msta_pkg.
module msta_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msta_pkg::CFG_DATA_W-1:0]   cfg_data,
	output msta_pkg::cfg_t                    cfg
);
	import msta_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_high_limit     <= LIMIT_W'(400);
			cfg_q.temp_low_limit      <= LIMIT_W'(50);
			cfg_q.humidity_high_limit <= LIMIT_W'(800);
			cfg_q.dust_high_limit     <= LIMIT_W'(1500);
			cfg_q.light_low_limit     <= LIMIT_W'(1000);
			cfg_q.alert_delay_ms      <= DELAY_W'(60000);
			cfg_q.rebuzz_interval_ms  <= DELAY_W'(10000);
			cfg_q.tick_period_ms      <= TICK_W'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_HIGH:  cfg_q.temp_high_limit     <= cfg_data[LIMIT_W-1:0];
				REG_TEMP_LOW:   cfg_q.temp_low_limit      <= cfg_data[LIMIT_W-1:0];
				REG_HUMID_HIGH: cfg_q.humidity_high_limit <= cfg_data[LIMIT_W-1:0];
				REG_DUST_HIGH:  cfg_q.dust_high_limit     <= cfg_data[LIMIT_W-1:0];
				REG_LIGHT_LOW:  cfg_q.light_low_limit     <= cfg_data[LIMIT_W-1:0];
				REG_ALERT_DLY:  cfg_q.alert_delay_ms      <= cfg_data[DELAY_W-1:0];
				REG_REBUZZ_INT: cfg_q.rebuzz_interval_ms  <= cfg_data[DELAY_W-1:0];
				REG_TICK_PER:   cfg_q.tick_period_ms      <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/msta_limit_check.sv
// Compares each reading against its limits and flags the bad channels.
// Depends on msta_pkg.
module msta_limit_check (
	input  msta_pkg::rd_t                 rd,
	input  msta_pkg::cfg_t                cfg,
	output logic [msta_pkg::CHANNELS-1:0] now_bad
);
	import msta_pkg::*;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			case (i)
				0: now_bad[i] = (rd.temp_reading > cfg.temp_high_limit) ||
					(rd.temp_reading < cfg.temp_low_limit);
				1: now_bad[i] = rd.humidity_reading > cfg.humidity_high_limit;
				2: now_bad[i] = rd.dust_reading > cfg.dust_high_limit;
				3: now_bad[i] = rd.light_reading < cfg.light_low_limit;
				default: now_bad[i] = 1'b0;
			endcase
		end
	end

endmodule

// File: hw/rtl/msta_channel.sv
// One channel: bad flag, saturating bad-time and re-buzz counters, alert flag.
// Depends on msta_pkg; state advances once per word moved to the output.
module msta_channel (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               now_bad,
	input  msta_pkg::cfg_t     cfg,
	output msta_pkg::chan_evt_t evt
);
	import msta_pkg::*;

	logic                  bad_q;
	logic                  alert_sent_q;
	logic [TIME_WIDTH-1:0] bad_time_q;
	logic [TIME_WIDTH-1:0] rebuzz_time_q;

	logic [TIME_WIDTH:0]   bad_sum;
	logic [TIME_WIDTH:0]   reb_sum;
	logic [TIME_WIDTH-1:0] bad_sat;
	logic [TIME_WIDTH-1:0] reb_sat;
	logic                  alert_hit;
	logic                  rebuzz_hit;
	logic                  delay_reached;

	assign bad_sum = {1'b0, bad_time_q} + (TIME_WIDTH+1)'(cfg.tick_period_ms);
	assign reb_sum = {1'b0, rebuzz_time_q} + (TIME_WIDTH+1)'(cfg.tick_period_ms);
	assign bad_sat = bad_sum[TIME_WIDTH] ? '1 : bad_sum[TIME_WIDTH-1:0];
	assign reb_sat = reb_sum[TIME_WIDTH] ? '1 : reb_sum[TIME_WIDTH-1:0];

	assign alert_hit     = (CMP_W'(bad_sat) >= CMP_W'(cfg.alert_delay_ms)) && !alert_sent_q;
	assign rebuzz_hit    = CMP_W'(reb_sat) >= CMP_W'(cfg.rebuzz_interval_ms);
	assign delay_reached = CMP_W'(bad_time_q) >= CMP_W'(cfg.alert_delay_ms);

	always_comb begin
		evt.bad   = now_bad;
		evt.buzz  = (bad_q && now_bad && rebuzz_hit) || (!bad_q && now_bad);
		evt.alert = bad_q && now_bad && alert_hit;
		evt.recov = bad_q && !now_bad && delay_reached;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q         <= 1'b0;
			alert_sent_q  <= 1'b0;
			bad_time_q    <= '0;
			rebuzz_time_q <= '0;
		end else if (adv) begin
			bad_q <= now_bad;
			if (bad_q && now_bad) begin
				bad_time_q    <= bad_sat;
				rebuzz_time_q <= rebuzz_hit ? '0 : reb_sat;
				if (alert_hit)
					alert_sent_q <= 1'b1;
			end else if (bad_q) begin
				bad_time_q    <= '0;
				rebuzz_time_q <= '0;
				alert_sent_q  <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/multi_sensor_threshold_alarm_top.sv
// Top level of the multi-sensor threshold alarm.
// Depends on msta_pkg, msta_cfg_regs, msta_limit_check and msta_channel.
//
// Usage:
//   Input stream (s_axis_*): one word per tick carrying four 16-bit readings.
//   Output stream (m_axis_*): one result word per input word: buzzer pulse,
//   per-channel bad, alert and recovered flags.
//   Config port: cfg_we/cfg_index/cfg_data writes one register per cycle;
//   write only while no word is in flight.
// Path: an accepted word is held in the input register; its result is loaded
//   into the output register when the word advances and is presented from
//   there until it is taken.
// Throughput: one word per cycle unless stalled. The channel compare and
//   counter update is a single combinational pass between the two registers.
// Stall: while m_axis_tready is low the result holds and the input register
//   fills; s_axis_tready drops only when both registers are occupied. Channel
//   state advances only when a word moves into the output register.
// Reset: arst_n clears the pipeline, all channel state, and loads the default
//   limits, delays and tick period.
module multi_sensor_threshold_alarm_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// temp_reading, humidity_reading, dust_reading, light_reading
	input  logic [msta_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// buzzer_pulse, bad_flags, alert_flags, recovered_flags, zero fill
	output logic [msta_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [msta_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msta_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import msta_pkg::*;

	cfg_t                   cfg;
	rd_t                    rd_s1;
	logic                   valid_s1;
	logic                   adv;
	logic [CHANNELS-1:0]    now_bad;
	chan_evt_t              evt [CHANNELS];
	logic [CHANNELS-1:0]    buzz_v;
	logic [FLAG_W-1:0]      bad_f;
	logic [FLAG_W-1:0]      alert_f;
	logic [FLAG_W-1:0]      recov_f;
	logic                   out_valid_s2;
	logic [OUT_BITS-1:0]    out_s2;
	logic [OUT_BITS-1:0]    result;

	msta_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msta_limit_check u_check (
		.rd      (rd_s1),
		.cfg     (cfg),
		.now_bad (now_bad)
	);

	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		msta_channel u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.now_bad (now_bad[g]),
			.cfg     (cfg),
			.evt     (evt[g])
		);
	end

	assign adv           = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// channels at or above FLAG_W are left out of the flag fields; unused flag bits read zero
	always_comb begin
		bad_f   = '0;
		alert_f = '0;
		recov_f = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			buzz_v[i] = evt[i].buzz;
			if (i < FLAG_W) begin
				bad_f[i]   = evt[i].bad;
				alert_f[i] = evt[i].alert;
				recov_f[i] = evt[i].recov;
			end
		end
	end

	assign result = {recov_f, alert_f, bad_f, |buzz_v};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv)
				out_valid_s2 <= 1'b1;
			else if (m_axis_tready)
				out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			rd_s1 <= rd_t'(s_axis_tdata);
		if (adv)
			out_s2 <= result;
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(out_s2);

endmodule

// File: hw/rtl/msta_checker.sv
// Port-level checks for the threshold alarm, bound to the top level.
// Depends on msta_pkg and multi_sensor_threshold_alarm_top.
module msta_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [msta_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import msta_pkg::*;

	logic [FLAG_W-1:0] bad_f;
	logic [FLAG_W-1:0] alert_f;
	logic [FLAG_W-1:0] recov_f;

	assign bad_f   = m_axis_tdata[FLAG_W:1];
	assign alert_f = m_axis_tdata[2*FLAG_W:FLAG_W+1];
	assign recov_f = m_axis_tdata[3*FLAG_W:2*FLAG_W+1];

	// a stalled result word stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word dropped or changed under stall");

	// an alert only fires on a channel that is still bad
	a_alert_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (alert_f & ~bad_f) == '0)
		else $error("alert on a channel that is good");

	// a recovery only fires on a channel that is now good
	a_recov_good: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (recov_f & bad_f) == '0)
		else $error("recovery on a channel that is bad");

	// with the output register empty the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind multi_sensor_threshold_alarm_top msta_checker u_msta_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
